// ----- rtl/gtr_pkg.sv -----
// ----------------------------------------------------------------------------
// Glyph text renderer package
// Field widths, operation and status codes and the sequencer state type
// shared by the renderer files.
// ----------------------------------------------------------------------------
package gtr_pkg;

   // Field widths of the request and response transactions.
   localparam int OP_W         = 3;
   localparam int CODE_W       = 8;
   localparam int FONT_ADDR_W  = 12;
   localparam int VALUE_W      = 8;
   localparam int FRAME_ADDR_W = 9;
   localparam int STATUS_W     = 2;
   localparam int CURSOR_OUT_W = 8;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOAD_FONT   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR_LINE  = 3'd1;
   localparam logic [OP_W-1:0] OP_DRAW_CHAR   = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_FRAME  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CODE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LINE_FULL = 2'd2;

   // The font starts at the space character.
   localparam int FIRST_CODE  = 32;
   localparam int FRAME_PAGES = 4;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_READ,
      ST_DRAW_SETUP,
      ST_DRAW,
      ST_DRAW_END,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/glyph_text_renderer.sv -----
// ----------------------------------------------------------------------------
// Glyph text renderer
// Draws proportional glyphs from a loadable font into a four-page monochrome
// frame store, with one column cursor for each of two text lines.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Transaction
//   req_*     in         req_valid / req_ready  one operation with its fields
//   rsp_*     out        rsp_valid / rsp_ready  read value, status, cursor
//
// A draw is paced by the single font memory port, which delivers one glyph
// byte per cycle; clears are paced by the single frame write port, which
// zeroes one byte per cycle.
// After reset the frame store is swept to zero before req_ready first rises.
// A finished response waits in the output register, so a new request is
// taken while rsp_valid is stalled; the next response waits in ST_DONE.
// ----------------------------------------------------------------------------
module glyph_text_renderer #(
   parameter int GLYPH_COLUMNS  = 12,
   parameter int GLYPH_BYTES    = 25,
   parameter int GLYPH_COUNT    = 96,
   parameter int SCREEN_COLUMNS = 128
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gtr_pkg::OP_W-1:0]          req_operation,
   input  logic                              req_line_select,
   input  logic [gtr_pkg::CODE_W-1:0]        req_char_code,
   input  logic [gtr_pkg::FONT_ADDR_W-1:0]   req_font_address,
   input  logic [gtr_pkg::VALUE_W-1:0]       req_font_value,
   input  logic [gtr_pkg::FRAME_ADDR_W-1:0]  req_frame_address,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gtr_pkg::VALUE_W-1:0]       rsp_read_value,
   output logic [gtr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [gtr_pkg::CURSOR_OUT_W-1:0]  rsp_cursor_after
);

   import gtr_pkg::*;

   // Storage sizes and the widths that follow from them.
   localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_BYTES;
   localparam int FONT_AW     = $clog2(FONT_DEPTH);
   localparam int FRAME_DEPTH = FRAME_PAGES * SCREEN_COLUMNS;
   localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
   localparam int CUR_W       = $clog2(SCREEN_COLUMNS + 1);
   localparam int SUM_W       = ((CUR_W > VALUE_W) ? CUR_W : VALUE_W) + 1;
   localparam int COL_W       = $clog2(SCREEN_COLUMNS + GLYPH_COLUMNS);
   localparam int REL_MAX     = 2 * GLYPH_COLUMNS;
   localparam int REL_W       = $clog2(REL_MAX + 1);
   localparam int IDX_W       = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;

   // Memories. The font store has no reset; the frame store is swept to zero.
   logic [VALUE_W-1:0] font_mem  [FONT_DEPTH];
   logic [VALUE_W-1:0] frame_mem [FRAME_DEPTH];

   // Sequencer state and the captured request.
   state_type               state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic                    line_ff, line_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic [FONT_ADDR_W-1:0]  faddr_ff, faddr_in;
   logic [VALUE_W-1:0]      fval_ff, fval_in;
   logic [FRAME_ADDR_W-1:0] raddr_ff, raddr_in;

   // Line cursors.
   logic [CUR_W-1:0]        top_cur_ff, top_cur_in;
   logic [CUR_W-1:0]        bot_cur_ff, bot_cur_in;

   // Draw sequencer: the issue side walks the glyph bytes, the stage side writes,
   // or for byte 0 keeps as the advance, the byte returned in the cycle after its issue.
   logic [FONT_AW-1:0]      base_ff, base_in;
   logic [REL_W-1:0]        rel_ff, rel_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    lower_ff, lower_in;
   logic                    stg_valid_ff, stg_valid_in;
   logic                    stg_adv_ff, stg_adv_in;
   logic                    stg_zero_ff, stg_zero_in;
   logic [IDX_W-1:0]        stg_idx_ff, stg_idx_in;
   logic                    stg_lower_ff, stg_lower_in;
   logic [VALUE_W-1:0]      adv_ff, adv_in;

   // Clearing sweep.
   logic [FRAME_AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [FRAME_AW-1:0]     clr_last_ff, clr_last_in;

   // Results and the output register.
   logic [VALUE_W-1:0]      res_read_ff, res_read_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]      rsp_read_ff, rsp_read_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [CURSOR_OUT_W-1:0] rsp_cursor_ff, rsp_cursor_in;

   // Memory ports.
   logic [VALUE_W-1:0]      font_q_ff;
   logic [VALUE_W-1:0]      frame_q_ff;
   logic                    font_we, font_re;
   logic [FONT_AW-1:0]      font_waddr, font_raddr;
   logic                    frame_we, frame_re;
   logic [FRAME_AW-1:0]     frame_waddr, frame_raddr;
   logic [VALUE_W-1:0]      frame_wdata;

   // Shared datapath terms.
   logic [CUR_W-1:0]        cur_sel;
   logic                    code_ok;
   logic                    line_full;
   logic                    out_free;
   logic [VALUE_W-1:0]      glyph_data;
   logic [COL_W-1:0]        col;
   logic [1:0]              page;
   logic [SUM_W-1:0]        adv_sum;
   logic [CUR_W-1:0]        cur_next;
   logic [FRAME_AW-1:0]     line_base;

   assign cur_sel    = line_ff ? bot_cur_ff : top_cur_ff;
   assign code_ok    = (32'(code_ff) >= FIRST_CODE) &&
                       (32'(code_ff) < FIRST_CODE + GLYPH_COUNT);
   assign line_full  = 32'(cur_sel) >= SCREEN_COLUMNS;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Glyph bytes past the glyph's size read as zero.
   assign glyph_data = stg_zero_ff ? '0 : font_q_ff;
   assign col        = COL_W'(cur_sel) + COL_W'(stg_idx_ff);
   assign page       = {line_ff, stg_lower_ff};
   assign line_base  = line_ff ? FRAME_AW'(2 * SCREEN_COLUMNS) : '0;

   // Cursor advance saturates at the right edge of the screen.
   assign adv_sum    = SUM_W'(cur_sel) + SUM_W'(adv_ff);
   assign cur_next   = (adv_sum > SUM_W'(SCREEN_COLUMNS)) ?
                       CUR_W'(SCREEN_COLUMNS) : CUR_W'(adv_sum);

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_read_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_cursor_after = rsp_cursor_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (clr_addr_ff == clr_last_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_CLEAR_LINE, OP_CLEAR_ALL: state_in = ST_CLEAR;
               OP_READ_FRAME:               state_in = ST_READ;
               OP_DRAW_CHAR: begin
                  if (code_ok && !line_full) state_in = ST_DRAW_SETUP;
                  else                       state_in = ST_DONE;
               end
               default:                     state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: begin
            if (clr_addr_ff == clr_last_ff) state_in = ST_DONE;
         end
         ST_READ:       state_in = ST_DONE;
         ST_DRAW_SETUP: state_in = ST_DRAW;
         ST_DRAW: begin
            if (rel_ff == REL_W'(REL_MAX)) state_in = ST_DRAW_END;
         end
         ST_DRAW_END:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      op_in         = op_ff;
      line_in       = line_ff;
      code_in       = code_ff;
      faddr_in      = faddr_ff;
      fval_in       = fval_ff;
      raddr_in      = raddr_ff;
      top_cur_in    = top_cur_ff;
      bot_cur_in    = bot_cur_ff;
      base_in       = base_ff;
      rel_in        = rel_ff;
      idx_in        = idx_ff;
      lower_in      = lower_ff;
      stg_valid_in  = 1'b0;
      stg_adv_in    = stg_adv_ff;
      stg_zero_in   = stg_zero_ff;
      stg_idx_in    = stg_idx_ff;
      stg_lower_in  = stg_lower_ff;
      adv_in        = adv_ff;
      clr_addr_in   = clr_addr_ff;
      clr_last_in   = clr_last_ff;
      res_read_in   = res_read_ff;
      res_status_in = res_status_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_read_in   = rsp_read_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cursor_in = rsp_cursor_ff;
      font_we       = 1'b0;
      font_waddr    = FONT_AW'(faddr_ff);
      font_re       = 1'b0;
      font_raddr    = base_ff + FONT_AW'(rel_ff);
      frame_we      = 1'b0;
      frame_waddr   = clr_addr_ff;
      frame_wdata   = '0;
      frame_re      = 1'b0;
      frame_raddr   = FRAME_AW'(raddr_ff);

      // The glyph byte that came back from the font memory this cycle.
      if (stg_valid_ff) begin
         if (stg_adv_ff) begin
            adv_in = glyph_data;
         end else if (32'(col) < SCREEN_COLUMNS) begin
            frame_we    = 1'b1;
            frame_waddr = FRAME_AW'(page) * FRAME_AW'(SCREEN_COLUMNS) +
                          FRAME_AW'(col);
            frame_wdata = glyph_data;
         end
      end

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            frame_we    = 1'b1;
            frame_waddr = clr_addr_ff;
            frame_wdata = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            op_in    = req_operation;
            line_in  = req_line_select;
            code_in  = req_char_code;
            faddr_in = req_font_address;
            fval_in  = req_font_value;
            raddr_in = req_frame_address;
         end
         ST_EXEC: begin
            res_read_in   = '0;
            res_status_in = STATUS_OK;
            case (op_ff)
               OP_LOAD_FONT: begin
                  font_we = 32'(faddr_ff) < FONT_DEPTH;
               end
               OP_CLEAR_LINE: begin
                  clr_addr_in = line_base;
                  clr_last_in = line_base + FRAME_AW'(2 * SCREEN_COLUMNS - 1);
                  if (line_ff) bot_cur_in = '0;
                  else         top_cur_in = '0;
               end
               OP_CLEAR_ALL: begin
                  clr_addr_in = '0;
                  clr_last_in = FRAME_AW'(FRAME_DEPTH - 1);
               end
               OP_READ_FRAME: begin
                  rd_ok_in = 32'(raddr_ff) < FRAME_DEPTH;
                  frame_re = 1'b1;
               end
               OP_DRAW_CHAR: begin
                  if (!code_ok)      res_status_in = STATUS_BAD_CODE;
                  else if (line_full) res_status_in = STATUS_LINE_FULL;
               end
               default: begin
                  res_status_in = STATUS_OK;
               end
            endcase
         end
         ST_READ: begin
            res_read_in = rd_ok_ff ? frame_q_ff : '0;
         end
         ST_DRAW_SETUP: begin
            base_in  = FONT_AW'(GLYPH_BYTES) *
                       FONT_AW'(code_ff - CODE_W'(FIRST_CODE));
            rel_in   = '0;
            idx_in   = '0;
            lower_in = 1'b0;
         end
         ST_DRAW: begin
            // Byte 0 is the advance; then upper and lower bytes alternate.
            font_re      = 32'(rel_ff) < GLYPH_BYTES;
            stg_valid_in = 1'b1;
            stg_adv_in   = (rel_ff == '0);
            stg_zero_in  = 32'(rel_ff) >= GLYPH_BYTES;
            stg_idx_in   = idx_ff;
            stg_lower_in = lower_ff;
            rel_in       = rel_ff + 1'b1;
            if (rel_ff != '0) begin
               if (lower_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  lower_in = 1'b0;
               end else begin
                  lower_in = 1'b1;
               end
            end
         end
         ST_DRAW_END: begin
            if (line_ff) bot_cur_in = cur_next;
            else         top_cur_in = cur_next;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = res_read_ff;
               rsp_status_in = res_status_ff;
               rsp_cursor_in = CURSOR_OUT_W'(cur_sel);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_addr_ff  <= '0;
         clr_last_ff  <= FRAME_AW'(FRAME_DEPTH - 1);
         top_cur_ff   <= '0;
         bot_cur_ff   <= '0;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_last_ff  <= clr_last_in;
         top_cur_ff   <= top_cur_in;
         bot_cur_ff   <= bot_cur_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      line_ff       <= line_in;
      code_ff       <= code_in;
      faddr_ff      <= faddr_in;
      fval_ff       <= fval_in;
      raddr_ff      <= raddr_in;
      base_ff       <= base_in;
      rel_ff        <= rel_in;
      idx_ff        <= idx_in;
      lower_ff      <= lower_in;
      stg_adv_ff    <= stg_adv_in;
      stg_zero_ff   <= stg_zero_in;
      stg_idx_ff    <= stg_idx_in;
      stg_lower_ff  <= stg_lower_in;
      adv_ff        <= adv_in;
      res_read_ff   <= res_read_in;
      res_status_ff <= res_status_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cursor_ff <= rsp_cursor_in;
   end

   // Font store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (font_we) font_mem[font_waddr] <= fval_ff;
      if (font_re) font_q_ff <= font_mem[font_raddr];
   end

   // Frame store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
      if (frame_re) frame_q_ff <= frame_mem[frame_raddr];
   end

`ifndef ASSERT_OFF
   // An accepted request always starts execution on the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start execution");

   // A response is only raised out of the completion state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside completion state");

   // The frame store is never written while the block waits for requests.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !frame_we)
      else $error("frame write while idle");

   // Both cursors stay within the screen width plus the saturated position.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |->
         ((32'(top_cur_ff) <= SCREEN_COLUMNS) && (32'(bot_cur_ff) <= SCREEN_COLUMNS)))
      else $error("cursor beyond saturation limit");
`endif

endmodule
